// ===== hw/rtl/sxl_pkg.sv =====
`timescale 1ns / 1ps

package sxl_pkg;

  // One source byte and its end-of-source mark.
  typedef struct packed {
    logic [7:0] src_byte;
    logic       is_final;
  } in_item_t;

  // One result of the lexer.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_value;
    logic [2:0] token_kind;
    logic [1:0] error_code;
    logic       run_last;
  } result_t;

  // Results that one source byte causes, at most three.
  localparam int unsigned RunMax = 3;

  typedef struct packed {
    result_t [RunMax-1:0] res;
    logic    [1:0]        cnt;
  } run_t;

  // Lexer state carried from one byte to the next.
  typedef struct packed {
    logic       line_comment;
    logic       block_comment;
    logic       single_quoted;
    logic       double_quoted;
    logic       escape_pending;
    logic [7:0] prior_byte;
    logic [2:0] open_token_kind;
  } lex_state_t;

  // Result kinds.
  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERR   = 2'd2;

  // Token types.
  localparam logic [2:0] TK_NONE    = 3'd0;
  localparam logic [2:0] TK_CALL    = 3'd1;
  localparam logic [2:0] TK_END     = 3'd2;
  localparam logic [2:0] TK_STRING  = 3'd3;
  localparam logic [2:0] TK_NUMERIC = 3'd4;
  localparam logic [2:0] TK_IDENT   = 3'd5;

  // Error codes.
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_ESCAPE     = 2'd1;
  localparam logic [1:0] ERR_BACKSLASH  = 2'd2;

  // Characters the lexer decodes.
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_SEMI      = 8'h3B;
  localparam logic [7:0] CH_BAR       = 8'h7C;
  localparam logic [7:0] CH_HASH      = 8'h23;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;

  function automatic result_t mk_char(input logic [7:0] c);
    result_t r;
    r            = '0;
    r.kind       = KIND_CHAR;
    r.char_value = c;
    return r;
  endfunction

  function automatic result_t mk_close(input logic [2:0] t);
    result_t r;
    r            = '0;
    r.kind       = KIND_CLOSE;
    r.token_kind = t;
    return r;
  endfunction

  function automatic result_t mk_err(input logic [1:0] e);
    result_t r;
    r            = '0;
    r.kind       = KIND_ERR;
    r.error_code = e;
    return r;
  endfunction

endpackage

// ===== hw/rtl/sxl_decode.sv =====
`timescale 1ns / 1ps

// Decodes one byte against the current state into the next state and the
// run of results that the byte causes.
module sxl_decode import sxl_pkg::*; (
  input  in_item_t   item_i,
  input  lex_state_t state_i,
  output lex_state_t state_o,
  output run_t       run_o
);

  always_comb begin
    lex_state_t s;
    run_t       r;
    logic       cmt;
    logic       qt;
    logic [7:0] c;

    s   = state_i;
    r   = '0;
    c   = item_i.src_byte;
    cmt = state_i.line_comment | state_i.block_comment;
    qt  = state_i.single_quoted | state_i.double_quoted;

    if (state_i.escape_pending) begin
      // Inside quotes the escaped byte is taken as it is; outside quotes it gives an escape error.
      if (qt) begin
        r.res[r.cnt] = mk_char(c);
      end else begin
        r.res[r.cnt] = mk_err(ERR_ESCAPE);
      end
      r.cnt            = r.cnt + 2'd1;
      s.escape_pending = 1'b0;
    end else begin
      case (c)
        CH_LPAREN, CH_RPAREN: begin
          if (!cmt) begin
            if (qt) begin
              r.res[r.cnt] = mk_char(c);
              r.cnt        = r.cnt + 2'd1;
            end else begin
              r.res[r.cnt] = mk_close(s.open_token_kind);
              r.cnt        = r.cnt + 2'd1;
              r.res[r.cnt] = mk_close((c == CH_LPAREN) ? TK_CALL : TK_END);
              r.cnt        = r.cnt + 2'd1;
              s.open_token_kind = TK_NONE;
            end
          end
        end
        CH_TAB, CH_SPACE: begin
          if (!cmt) begin
            if (state_i.single_quoted) begin
              s.single_quoted   = 1'b0;
              r.res[r.cnt]      = mk_close(s.open_token_kind);
              r.cnt             = r.cnt + 2'd1;
              s.open_token_kind = TK_NONE;
            end else if (state_i.double_quoted) begin
              r.res[r.cnt] = mk_char(c);
              r.cnt        = r.cnt + 2'd1;
            end else if (c == CH_SPACE) begin
              r.res[r.cnt]      = mk_close(s.open_token_kind);
              r.cnt             = r.cnt + 2'd1;
              s.open_token_kind = TK_NONE;
            end
          end
        end
        CH_NEWLINE: begin
          if (state_i.line_comment) begin
            s.line_comment = 1'b0;
          end else if (state_i.single_quoted) begin
            s.single_quoted   = 1'b0;
            r.res[r.cnt]      = mk_close(s.open_token_kind);
            r.cnt             = r.cnt + 2'd1;
            s.open_token_kind = TK_NONE;
          end else if (state_i.double_quoted) begin
            r.res[r.cnt] = mk_char(c);
            r.cnt        = r.cnt + 2'd1;
          end
        end
        CH_BACKSLASH: begin
          if (!qt && !cmt) begin
            r.res[r.cnt] = mk_err(ERR_BACKSLASH);
            r.cnt        = r.cnt + 2'd1;
          end else begin
            s.escape_pending = 1'b1;
          end
        end
        CH_DQUOTE: begin
          if (!cmt) begin
            if (state_i.double_quoted) begin
              s.double_quoted   = 1'b0;
              r.res[r.cnt]      = mk_close(s.open_token_kind);
              r.cnt             = r.cnt + 2'd1;
              s.open_token_kind = TK_NONE;
            end else if (state_i.single_quoted) begin
              r.res[r.cnt] = mk_char(c);
              r.cnt        = r.cnt + 2'd1;
            end else begin
              r.res[r.cnt]      = mk_close(s.open_token_kind);
              r.cnt             = r.cnt + 2'd1;
              s.open_token_kind = TK_STRING;
              s.double_quoted   = 1'b1;
            end
          end
        end
        CH_SQUOTE: begin
          if (!cmt) begin
            if (state_i.single_quoted) begin
              s.single_quoted   = 1'b0;
              r.res[r.cnt]      = mk_close(s.open_token_kind);
              r.cnt             = r.cnt + 2'd1;
              s.open_token_kind = TK_NONE;
            end else if (state_i.double_quoted) begin
              r.res[r.cnt] = mk_char(c);
              r.cnt        = r.cnt + 2'd1;
            end else begin
              r.res[r.cnt]      = mk_close(s.open_token_kind);
              r.cnt             = r.cnt + 2'd1;
              s.open_token_kind = TK_STRING;
              s.single_quoted   = 1'b1;
            end
          end
        end
        CH_SEMI: begin
          if (!cmt) begin
            if (qt) begin
              r.res[r.cnt] = mk_char(c);
              r.cnt        = r.cnt + 2'd1;
            end else begin
              s.line_comment = 1'b1;
            end
          end
        end
        CH_BAR: begin
          if (qt) begin
            r.res[r.cnt] = mk_char(c);
            r.cnt        = r.cnt + 2'd1;
          end
          if (state_i.prior_byte == CH_HASH) begin
            s.block_comment = 1'b1;
          end
        end
        CH_HASH: begin
          if (qt) begin
            r.res[r.cnt] = mk_char(c);
            r.cnt        = r.cnt + 2'd1;
          end
          if (state_i.prior_byte == CH_BAR) begin
            s.block_comment = 1'b0;
          end
        end
        default: begin
          if (!cmt) begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
              s.open_token_kind = TK_NUMERIC;
            end else if (!qt) begin
              s.open_token_kind = TK_IDENT;
            end
            r.res[r.cnt] = mk_char(c);
            r.cnt        = r.cnt + 2'd1;
          end
        end
      endcase
    end

    s.prior_byte = c;

    // The last source byte closes whatever token is still open.
    if (item_i.is_final) begin
      r.res[r.cnt]      = mk_close(s.open_token_kind);
      r.cnt             = r.cnt + 2'd1;
      s.open_token_kind = TK_NONE;
    end

    if (r.cnt != 2'd0) begin
      r.res[r.cnt - 2'd1].run_last = 1'b1;
    end

    state_o = s;
    run_o   = r;
  end

endmodule

// ===== hw/rtl/sxl_runbuf.sv =====
`timescale 1ns / 1ps

// Holds the run of one byte and hands it out one result per cycle while the output is ready.
module sxl_runbuf import sxl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  run_t    run_i,
  output logic    can_load_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  result_t [RunMax-1:0] slot_q, slot_d;
  logic    [1:0]        cnt_q, cnt_d;
  logic                 pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = slot_q[0];
  // A new run may enter once the last result of the current one leaves.
  assign can_load_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);

  always_comb begin
    slot_d = slot_q;
    cnt_d  = cnt_q;
    if (load_i) begin
      slot_d = run_i.res;
      cnt_d  = run_i.cnt;
    end else if (pop) begin
      slot_d[0] = slot_q[1];
      slot_d[1] = slot_q[2];
      cnt_d     = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  a_last_marks_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> out_data_o.run_last)
    else $error("final buffered result lacks its run_last mark");

  a_no_early_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 || cnt_q == 2'd3) |-> !out_data_o.run_last)
    else $error("run_last set before the end of a run");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && run_i.cnt != 2'd0) |=> out_valid_o)
    else $error("loaded run not presented on the output");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> can_load_o)
    else $error("run loaded while the buffer is still busy");

endmodule

// ===== hw/rtl/sexpr_token_lexer.sv =====
`timescale 1ns / 1ps
// The first result of a byte is registered and shown in the cycle after its transaction.
// Throughput: one byte per cycle while each byte gives at most one result and the output is
// ready; a byte with more (up to three) holds input while the run buffer drains one a cycle.
// A byte with no result waits for a free buffer too. Reset (async, active low) clears all lexer
// flags, the previous byte, the open token type and the run buffer; no clearing pass follows.

module sexpr_token_lexer import sxl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output result_t  out_data_o
);

  // Lexer state: comment and quote flags, pending escape, previous byte
  // (needed for the two-byte block comment markers) and the open token type.
  lex_state_t state_q, state_d;
  lex_state_t state_next;
  run_t       run;
  logic       accept;

  assign accept = in_valid_i && in_ready_o;

  // The whole per-byte decision is one short combinational pass from the
  // current state and the incoming byte.
  sxl_decode u_decode (
    .item_i  (in_data_i),
    .state_i (state_q),
    .state_o (state_next),
    .run_o   (run)
  );

  // The state moves only when a byte transaction completes.
  assign state_d = accept ? state_next : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  // The run buffer serves as the result register; it accepts the next run in
  // the same cycle in which the last result of the previous run is taken.
  sxl_runbuf u_runbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .run_i       (run),
    .can_load_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_escape_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && state_q.escape_pending) |=> !state_q.escape_pending)
    else $error("escape flag survived the escaped byte");

  a_final_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.is_final) |=> (state_q.open_token_kind == TK_NONE))
    else $error("token still open after the final byte");

  a_prior_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q.prior_byte == $past(in_data_i.src_byte)))
    else $error("previous byte not captured");

endmodule
